### hw/rtl/ssim_pkg.sv
// Shared types and constants for the square spiral index map.
`default_nettype none
package ssim_pkg;

  localparam int unsigned MAX_RADIUS = 32767;
  localparam int unsigned SQRT_STAGES = 8;
  localparam int unsigned SQRT_STEPS = 2;

  typedef struct packed {
    logic               kind;
    logic [31:0]        n;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sqrt_t;

endpackage
`default_nettype wire

### hw/rtl/square_spiral_index_map_core.sv
// Top level of the square spiral index map.
`default_nettype none
// Converts a spiral index to its x,y point (tuser 0) or a point to its index
// (tuser 1). Fully pipelined: one word per cycle unless the output stalls. The
// eight square-root stages are followed by multiply, subtract and quadrant
// stages. A word held at the output under a low m_tready stalls the whole
// pipeline in place.
module square_spiral_index_map_core
  import ssim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // spiral_index[31:0], coord_x[47:32], coord_y[63:48]
  input  wire logic        s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,  // result_x[15:0], result_y[31:16], result_index[63:32]
  output logic             m_tuser   // out_of_range
);

  logic        en;
  item_t       in_item;
  logic        a_valid;
  item_t       a_item;
  logic [15:0] a_root;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_item.kind = s_tuser;
  assign in_item.n    = s_tdata[31:0];
  assign in_item.x    = s_tdata[47:32];
  assign in_item.y    = s_tdata[63:48];

  ssim_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .out_valid (a_valid),
    .out_item  (a_item),
    .out_root  (a_root)
  );

  // ring, quadrant and multiplier operand
  logic [15:0] a_s0;
  logic [16:0] a_s1;
  logic [1:0]  a_q1;
  logic [15:0] a_m1;
  logic [15:0] a_op;
  logic        a_oor;
  logic        a_zero;

  always_comb begin
    logic [16:0]        ax, ay;
    logic signed [17:0] xs, ys, ss, mv;
    logic [16:0]        odd0, inner1;
    a_s0   = 16'((17'(a_root) + 17'd1) >> 1);
    odd0   = {a_s0, 1'b0} - 17'd1;
    xs     = 18'(a_item.x);
    ys     = 18'(a_item.y);
    ax     = xs[17] ? 17'(-xs) : 17'(xs);
    ay     = ys[17] ? 17'(-ys) : 17'(ys);
    a_s1   = (ax > ay) ? ax : ay;
    ss     = signed'({1'b0, a_s1});
    if (xs == ss && ys > -ss) begin
      a_q1 = 2'd0;
      mv   = ys + ss - 18'sd1;
    end else if (ys == ss) begin
      a_q1 = 2'd1;
      mv   = ss - 18'sd1 - xs;
    end else if (xs == -ss) begin
      a_q1 = 2'd2;
      mv   = ss - 18'sd1 - ys;
    end else begin
      a_q1 = 2'd3;
      mv   = xs + ss - 18'sd1;
    end
    a_m1   = mv[15:0];
    inner1 = {a_s1[15:0], 1'b0} - 17'd1;
    if (a_item.kind) begin
      a_op   = inner1[15:0];
      a_oor  = a_s1 > 17'(MAX_RADIUS);
      a_zero = a_s1 == 17'd0;
    end else begin
      a_op   = odd0[15:0];
      a_oor  = a_s0 > 16'(MAX_RADIUS);
      a_zero = a_item.n == 32'd0;
    end
  end

  logic        b_valid, b_kind, b_oor, b_zero;
  logic [31:0] b_n, b_prod;
  logic [15:0] b_s, b_m1;
  logic [1:0]  b_q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_kind <= a_item.kind;
      b_n    <= a_item.n;
      b_prod <= 32'(a_op) * 32'(a_op);
      b_s    <= a_item.kind ? a_s1[15:0] : a_s0;
      b_q1   <= a_q1;
      b_m1   <= a_m1;
      b_oor  <= a_oor;
      b_zero <= a_zero;
    end
  end

  logic        c_valid, c_kind, c_oor, c_zero;
  logic [18:0] c_r;
  logic [31:0] c_idx, b_diff;
  logic [15:0] c_s;

  assign b_diff = b_n - b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_kind <= b_kind;
      c_oor  <= b_oor;
      c_zero <= b_zero;
      c_s    <= b_s;
      c_r    <= b_diff[18:0];
      c_idx  <= b_prod + 32'({b_s, 1'b0} * b_q1) + 32'(b_m1);
    end
  end

  logic signed [15:0] d_x, d_y;

  always_comb begin
    logic [18:0]        side;
    logic [1:0]         q;
    logic [18:0]        m;
    logic signed [17:0] rs, ms;
    side = 19'({c_s, 1'b0});
    if (c_r < side) begin
      q = 2'd0;
      m = c_r;
    end else if (c_r < 19'(side * 2)) begin
      q = 2'd1;
      m = c_r - side;
    end else if (c_r < 19'(side * 3)) begin
      q = 2'd2;
      m = c_r - 19'(side * 2);
    end else begin
      q = 2'd3;
      m = c_r - 19'(side * 3);
    end
    rs = signed'({2'b0, c_s});
    ms = signed'({1'b0, m[16:0]});
    unique case (q)
      2'd0: begin
        d_x = rs[15:0];
        d_y = 16'(ms - rs + 18'sd1);
      end
      2'd1: begin
        d_x = 16'(rs - 18'sd1 - ms);
        d_y = rs[15:0];
      end
      2'd2: begin
        d_x = 16'(-rs);
        d_y = 16'(rs - 18'sd1 - ms);
      end
      default: begin
        d_x = 16'(ms - rs + 18'sd1);
        d_y = 16'(-rs);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= c_valid;
    end
    if (en) begin
      m_tuser <= c_oor && !c_zero;
      if (c_kind) begin
        m_tdata[31:0]  <= '0;
        m_tdata[63:32] <= (c_zero || c_oor) ? 32'd0 : c_idx;
      end else begin
        m_tdata[15:0]  <= (c_zero || c_oor) ? 16'd0 : d_x;
        m_tdata[31:16] <= (c_zero || c_oor) ? 16'd0 : d_y;
        m_tdata[63:32] <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ssim_isqrt.sv
// Pipelined exact integer square root of a 32-bit word, item carried alongside.
`default_nettype none
module ssim_isqrt
  import ssim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire item_t       in_item,
  output logic             out_valid,
  output item_t            out_item,
  output logic [15:0]      out_root
);

  logic  v   [0:SQRT_STAGES];
  item_t itm [0:SQRT_STAGES];
  sqrt_t st  [0:SQRT_STAGES];

  assign v[0]       = in_valid;
  assign itm[0]     = in_item;
  assign st[0].rem  = in_item.n;
  assign st[0].res  = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    sqrt_t nxt;

    always_comb begin
      logic [32:0] trial;
      logic [31:0] bitv;
      nxt = st[k];
      for (int j = 0; j < SQRT_STEPS; j++) begin
        bitv  = 32'd1 << (30 - 2 * (k * SQRT_STEPS + j));
        trial = {1'b0, nxt.res} + {1'b0, bitv};
        if ({1'b0, nxt.rem} >= trial) begin
          nxt.rem = nxt.rem - trial[31:0];
          nxt.res = (nxt.res >> 1) + bitv;
        end else begin
          nxt.res = nxt.res >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        itm[k+1] <= itm[k];
        st[k+1]  <= nxt;
      end
    end
  end

  assign out_valid = v[SQRT_STAGES];
  assign out_item  = itm[SQRT_STAGES];
  assign out_root  = st[SQRT_STAGES].res[15:0];

endmodule
`default_nettype wire

### sim/square_spiral_index_map_checker.sv
// Checker for the square spiral index map: predicts each result and compares it.
`timescale 1ns / 100ps
module square_spiral_index_map_checker
  import ssim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  input  wire logic        m_tuser,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic        oor;
    logic [63:0] data;
  } point_word_t;

  point_word_t expected_words[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'd1 << 32;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic point_word_t map_spiral(logic kind, logic [63:0] d);
    point_word_t w;
    longint unsigned n, t, s, r, side, q, m;
    longint x, y, ax, ay, sr, mm;
    logic signed [15:0] rx, ry;
    w = '0;
    if (kind == 1'b0) begin
      n = d[31:0];
      if (n != 0) begin
        t = int_sqrt(n);
        s = (t - 1) / 2;
        r = n - (2 * s + 1) * (2 * s + 1);
        s = s + 1;
        if (s > MAX_RADIUS) begin
          w.oor = 1'b1;
        end else begin
          side = 2 * s;
          q = r / side;
          m = r % side;
          sr = s;
          mm = m;
          case (q[1:0])
            2'd0: begin x = sr; y = mm - sr + 1; end
            2'd1: begin x = sr - 1 - mm; y = sr; end
            2'd2: begin x = -sr; y = sr - 1 - mm; end
            default: begin x = mm - sr + 1; y = -sr; end
          endcase
          rx = 16'(x);
          ry = 16'(y);
          w.data[15:0] = rx;
          w.data[31:16] = ry;
        end
      end
    end else begin
      x = $signed(d[47:32]);
      y = $signed(d[63:48]);
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      sr = ax > ay ? ax : ay;
      if (sr > MAX_RADIUS) begin
        w.oor = 1'b1;
      end else if (sr != 0) begin
        if (x == sr && y > -sr) begin q = 0; mm = y + sr - 1; end
        else if (y == sr) begin q = 1; mm = sr - 1 - x; end
        else if (x == -sr) begin q = 2; mm = sr - 1 - y; end
        else begin q = 3; mm = x + sr - 1; end
        n = (2 * sr - 1) * (2 * sr - 1) + 2 * sr * q + mm;
        w.data[63:32] = n[31:0];
      end
    end
    return w;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    point_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_words.insert(expected_words.size(), map_spiral(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word data=%h oor=%b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.data[15:0] !== m_tdata[15:0] || exp_w.data[31:16] !== m_tdata[31:16] ||
              exp_w.data[63:32] !== m_tdata[63:32] || exp_w.oor !== m_tuser) begin
            $display("%0t: mismatch expected data=%h oor=%b actual data=%h oor=%b",
                     $time, exp_w.data, exp_w.oor, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### sim/square_spiral_index_map_core_tb.sv
// Testbench top for the square spiral index map: stimulus and verdict.
`timescale 1ns / 100ps
module square_spiral_index_map_core_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;

  localparam int QUIET_LIMIT = 5000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  square_spiral_index_map_core i_dut (.*);

  square_spiral_index_map_checker i_checker (.*);

  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("square_spiral_index_map_core regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic kind, logic [31:0] idx, logic [15:0] cx, logic [15:0] cy);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {cy, cx, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(20)) - 16'd10;
      1: return $urandom_range(2) == 0 ? 16'h8000 : ($urandom_range(1) ? 16'h7fff : 16'h8001);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_index();
    longint unsigned k;
    case ($urandom_range(3))
      0: return $urandom_range(200);
      1: begin
        k = $urandom_range(32767);
        return 32'((2 * k + 1) * (2 * k + 1)) + $urandom_range(2) - 1;
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_word(0, 0, 0, 0);
    send_word(1, 0, 0, 0);
    send_word(0, 1, 0, 0);
    send_word(0, 8, 0, 0);
    send_word(0, 9, 0, 0);
    send_word(0, 32'hffff0000, 0, 0);
    send_word(0, 32'hfffe0001, 0, 0);
    send_word(0, 32'hfffe0000, 0, 0);
    send_word(0, 32'hffffffff, 0, 0);
    send_word(1, 0, 16'h7fff, 16'h7fff);
    send_word(1, 0, 16'h8001, 16'h8001);
    send_word(1, 0, 16'h7fff, 16'h8001);
    send_word(1, 0, 16'h8001, 16'h7fff);
    send_word(1, 0, 16'h8000, 0);
    send_word(1, 0, 0, 16'h8000);
    send_word(1, 0, 1, 16'hffff);
    send_word(1, 0, 16'hffff, 16'hffff);
    send_word(1, 32'hffffffff, 16'hffff, 16'hffff);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (60) send_word(0, rand_index(), 16'($urandom), 16'($urandom));
    join
    for (int i = 0; i < 1700; i++) begin
      calm = (i >= 600 && i < 900);
      if ($urandom_range(1)) send_word(0, rand_index(), 16'($urandom), 16'($urandom));
      else send_word(1, $urandom, rand_coord(), rand_coord());
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("square_spiral_index_map_core regression: pass");
    else $display("square_spiral_index_map_core regression: fail");
    $finish;
  end
endmodule
